// ===== rtl/bayer_bilinear_demosaic_unit_assert.svh =====
// Assertion macros for the bilinear demosaic unit checker
`ifndef BAYER_BILINEAR_DEMOSAIC_UNIT_ASSERT_SVH
`define BAYER_BILINEAR_DEMOSAIC_UNIT_ASSERT_SVH
// same-cycle implication under reset
`define BBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bbd check failed");
// next-cycle implication under reset
`define BBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bbd check failed");
`endif

// ===== rtl/bbd_pkg.sv =====
// Shared types and constants of the bilinear demosaic unit
package bbd_pkg;
	localparam int PIX_W  = 8;
	localparam int FW_W   = 13;
	localparam int FH_W   = 16;
	localparam int ROW_W  = 16;
	localparam int OCOL_W = 12;
	localparam int COL_W  = 14;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 1;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [3:0]       mask;
		logic             row_is1;
		logic             col_is1;
	} emit_item_t;
endpackage

// ===== rtl/bbd_raw_if.sv =====
// Raw pixel stream interface
interface bbd_raw_if;
	import bbd_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] raw_pixel;
	modport source (output valid, output raw_pixel, input ready);
	modport sink (input valid, input raw_pixel, output ready);
endinterface

// ===== rtl/bbd_rgb_if.sv =====
// RGB result stream interface
interface bbd_rgb_if;
	import bbd_pkg::*;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  red;
	logic [PIX_W-1:0]  green;
	logic [PIX_W-1:0]  blue;
	logic [ROW_W-1:0]  out_row;
	logic [OCOL_W-1:0] out_col;
	logic              last_of_run;
	logic              frame_done;
	modport source (output valid, output red, output green, output blue, output out_row,
		output out_col, output last_of_run, output frame_done, input ready);
	modport sink (input valid, input red, input green, input blue, input out_row,
		input out_col, input last_of_run, input frame_done, output ready);
endinterface

// ===== rtl/bayer_bilinear_demosaic_unit.sv =====
// Top level of the bilinear RGGB demosaic unit
//
// Raw Bayer samples enter on the raw channel (valid/ready, raw_pixel) in
// raster order, RGGB phase at the origin. Full RGB pixels leave on the rgb
// channel with their row, column, a last_of_run mark on the final result
// caused by an input sample, and frame_done on the bottom-right pixel.
// Frame width and height are set through the write port (wr_en, wr_index,
// wr_data); a write restarts the frame at row 0, column 0.
// One sample is accepted per cycle while raw ready is high. A sample that
// causes results passes the input stage, then the window, fed by the
// registered line store read, then the output register, and gives one
// result per cycle while the receiver is ready; samples at line ends and
// on the last line cause up to four; input stalls while the sequencer drains.
// At reset counters and the window clear, width reads 640 and height 480.
// When the receiver stalls the output register holds its word, the
// sequencer holds, and input ready falls once the input stage is full.
module bayer_bilinear_demosaic_unit #(
	parameter int MAX_LINE = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [bbd_pkg::IDX_W-1:0] wr_index,
	input  logic [bbd_pkg::CFG_W-1:0] wr_data,
	bbd_raw_if.sink                   raw,
	bbd_rgb_if.source                 rgb
);
	import bbd_pkg::*;

	localparam int CW = $clog2(MAX_LINE);
	localparam int EW = $clog2(MAX_LINE + 1);

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [CW-1:0]    c_q;
	logic [ROW_W-1:0] r_q;
	logic [EW-1:0]    we;
	logic [FH_W-1:0]  he;
	logic [15:0]      fw16;
	logic             acc, last_c, last_r;
	logic             v_s1;
	logic [PIX_W-1:0] px_s1;
	logic [CW-1:0]    c_s1;
	logic [ROW_W-1:0] r_s1;
	logic [PIX_W-1:0] top, mid;
	logic             take_ok, fire;
	emit_item_t       item;
	logic             lc_s1, lr_s1;

	assign fw16 = 16'(fw_q);
	always_comb begin
		priority if (fw16 < 16'd2) begin
			we = EW'(2);
		end else if (fw16 > 16'(MAX_LINE)) begin
			we = EW'(MAX_LINE);
		end else begin
			we = EW'(fw16);
		end
		he = (fh_q < FH_W'(2)) ? FH_W'(2) : fh_q;
	end

	assign last_c    = (EW'(c_q) == we - EW'(1));
	assign last_r    = (r_q == he - FH_W'(1));
	assign fire      = v_s1 && take_ok;
	assign raw.ready = !v_s1 || take_ok;
	assign acc       = raw.valid && raw.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_W'(640);
			fh_q <= FH_W'(480);
			c_q  <= '0;
			r_q  <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (wr_en) begin
				unique case (reg_idx_t'(wr_index))
					REG_FRAME_WIDTH:  fw_q <= wr_data[FW_W-1:0];
					REG_FRAME_HEIGHT: fh_q <= wr_data[FH_W-1:0];
					default:          fw_q <= fw_q;
				endcase
				c_q <= '0;
				r_q <= '0;
			end else if (acc) begin
				if (last_c) begin
					c_q <= '0;
					r_q <= last_r ? '0 : r_q + ROW_W'(1);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1 <= raw.raw_pixel;
			c_s1  <= c_q;
			r_s1  <= r_q;
			lc_s1 <= last_c;
			lr_s1 <= last_r;
		end
	end

	always_comb begin
		item.row     = r_s1;
		item.col     = COL_W'(c_s1);
		item.row_is1 = (r_s1 == ROW_W'(1));
		item.col_is1 = (c_s1 == CW'(1));
		item.mask[0] = (r_s1 != '0) && (c_s1 != '0);
		item.mask[1] = (r_s1 != '0) && lc_s1;
		item.mask[2] = (r_s1 != '0) && lr_s1 && (c_s1 != '0);
		item.mask[3] = (r_s1 != '0) && lr_s1 && lc_s1;
	end

	bbd_line_store #(
		.DEPTH (MAX_LINE),
		.AW    (CW)
	) u_line (
		.clk  (clk),
		.en   (acc),
		.addr (c_q),
		.par  (r_q[0]),
		.px   (raw.raw_pixel),
		.top  (top),
		.mid  (mid)
	);

	bbd_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire),
		.item    (item),
		.top     (top),
		.mid     (mid),
		.px      (px_s1),
		.take_ok (take_ok),
		.rgb     (rgb)
	);
endmodule

// ===== rtl/bbd_line_store.sv =====
// Two banked line stores, even and odd raw rows
module bbd_line_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [AW-1:0]             addr,
	input  logic                      par,
	input  logic [bbd_pkg::PIX_W-1:0] px,
	output logic [bbd_pkg::PIX_W-1:0] top,
	output logic [bbd_pkg::PIX_W-1:0] mid
);
	import bbd_pkg::*;

	logic [PIX_W-1:0] bank0 [DEPTH];
	logic [PIX_W-1:0] bank1 [DEPTH];
	logic [PIX_W-1:0] rd0_q;
	logic [PIX_W-1:0] rd1_q;
	logic             par_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd0_q <= bank0[addr];
			rd1_q <= bank1[addr];
			par_q <= par;
			if (par) begin
				bank1[addr] <= px;
			end else begin
				bank0[addr] <= px;
			end
		end
	end

	assign top = par_q ? rd1_q : rd0_q;
	assign mid = par_q ? rd0_q : rd1_q;
endmodule

// ===== rtl/bbd_emit.sv =====
// Neighbour window, result sequencer and output register
module bbd_emit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  bbd_pkg::emit_item_t       item,
	input  logic [bbd_pkg::PIX_W-1:0] top,
	input  logic [bbd_pkg::PIX_W-1:0] mid,
	input  logic [bbd_pkg::PIX_W-1:0] px,
	output logic                      take_ok,
	bbd_rgb_if.source                 rgb
);
	import bbd_pkg::*;

	logic [2:0][2:0][PIX_W-1:0] win_q;
	emit_item_t                 item_q;
	logic [3:0]                 mask_q;
	logic                       out_go;
	logic [1:0]                 k;
	logic [1:0]                 wi, wj, ui, di, lj, rj;
	logic                       top_f, left_f;
	logic [3:0]                 rest;
	logic [ROW_W-1:0]           orow;
	logic [COL_W-1:0]           ocol;
	logic [PIX_W-1:0]           ctr, nu, nd, nl, nr, cul, cur, cdl, cdr;
	logic [9:0]                 orth, diag;
	logic [8:0]                 horz, vert;
	logic [PIX_W-1:0]           r_c, g_c, b_c;

	function automatic logic [PIX_W-1:0] pick(input logic [2:0][2:0][PIX_W-1:0] w,
		input logic [1:0] i, input logic [1:0] j);
		logic [PIX_W-1:0] v;
		v = '0;
		if (i < 2'd3 && j < 2'd3) begin
			v = w[i][j];
		end
		return v;
	endfunction

	assign out_go = !rgb.valid || rgb.ready;

	always_comb begin
		priority if (mask_q[0]) begin
			k = 2'd0;
		end else if (mask_q[1]) begin
			k = 2'd1;
		end else if (mask_q[2]) begin
			k = 2'd2;
		end else begin
			k = 2'd3;
		end
		wi     = k[1] ? 2'd2 : 2'd1;
		wj     = k[0] ? 2'd2 : 2'd1;
		top_f  = !k[1] && item_q.row_is1;
		left_f = !k[0] && item_q.col_is1;
		ui     = top_f ? wi + 2'd1 : wi - 2'd1;
		di     = k[1] ? wi - 2'd1 : wi + 2'd1;
		lj     = left_f ? wj + 2'd1 : wj - 2'd1;
		rj     = k[0] ? wj - 2'd1 : wj + 2'd1;
		orow   = k[1] ? item_q.row : item_q.row - ROW_W'(1);
		ocol   = k[0] ? item_q.col : item_q.col - COL_W'(1);
		rest   = mask_q & ~(4'b0001 << k);
		ctr    = pick(win_q, wi, wj);
		nu     = pick(win_q, ui, wj);
		nd     = pick(win_q, di, wj);
		nl     = pick(win_q, wi, lj);
		nr     = pick(win_q, wi, rj);
		cul    = pick(win_q, ui, lj);
		cur    = pick(win_q, ui, rj);
		cdl    = pick(win_q, di, lj);
		cdr    = pick(win_q, di, rj);
		horz   = 9'(nl) + 9'(nr);
		vert   = 9'(nu) + 9'(nd);
		orth   = 10'(horz) + 10'(vert);
		diag   = 10'(cul) + 10'(cur) + 10'(cdl) + 10'(cdr);
		unique case ({orow[0], ocol[0]})
			2'b00: begin
				r_c = ctr;        g_c = orth[9:2]; b_c = diag[9:2];
			end
			2'b01: begin
				g_c = ctr;        r_c = horz[8:1]; b_c = vert[8:1];
			end
			2'b10: begin
				g_c = ctr;        r_c = vert[8:1]; b_c = horz[8:1];
			end
			default: begin
				b_c = ctr;        g_c = orth[9:2]; r_c = diag[9:2];
			end
		endcase
	end

	assign take_ok = (mask_q == 4'b0000) || (out_go && rest == 4'b0000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			mask_q    <= '0;
			rgb.valid <= 1'b0;
		end else begin
			if (out_go) begin
				rgb.valid <= (mask_q != 4'b0000);
				if (mask_q != 4'b0000) begin
					mask_q <= rest;
				end
			end
			if (load) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= top;
				win_q[1][2] <= mid;
				win_q[2][2] <= px;
				mask_q      <= item.mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
		if (out_go && mask_q != 4'b0000) begin
			rgb.red         <= r_c;
			rgb.green       <= g_c;
			rgb.blue        <= b_c;
			rgb.out_row     <= orow;
			rgb.out_col     <= OCOL_W'(ocol);
			rgb.last_of_run <= (rest == 4'b0000);
			rgb.frame_done  <= (k == 2'd3);
		end
	end
endmodule

// ===== rtl/bbd_checker.sv =====
// Port-level checker for the demosaic unit and its bind
`include "bayer_bilinear_demosaic_unit_assert.svh"
module bbd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [bbd_pkg::PIX_W-1:0]  red,
	input logic [bbd_pkg::ROW_W-1:0]  out_row,
	input logic [bbd_pkg::OCOL_W-1:0] out_col,
	input logic                       last_of_run,
	input logic                       frame_done
);
	import bbd_pkg::*;

	`BBD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(red))
	`BBD_ASSERT_NOW(a_done_last, clk, arst_n, out_valid && frame_done, last_of_run)
	`BBD_ASSERT_NOW(a_done_pos, clk, arst_n, out_valid && frame_done, out_row != '0)
	`BBD_ASSERT_NOW(a_done_col, clk, arst_n, out_valid && frame_done, out_col != '0 || out_row != '0)
endmodule

bind bayer_bilinear_demosaic_unit bbd_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (rgb.valid),
	.out_ready   (rgb.ready),
	.red         (rgb.red),
	.out_row     (rgb.out_row),
	.out_col     (rgb.out_col),
	.last_of_run (rgb.last_of_run),
	.frame_done  (rgb.frame_done)
);
